>>> rtl/cspi_pkg.sv
// shared types, constants and the u-step table of the cardinal spline interpolator
`default_nettype none

package cspi_pkg;

   // operand b of the shared multiplier: tension, 2-t or u, all fit 17 signed bits
   localparam int OPB_W = 17;
   // fraction bits of u and of the matrix entries
   localparam int U_BITS = 16;
   localparam int T_FRAC = 12;

   localparam logic signed [OPB_W-1:0] TWO_Q12 = 17'sd8192;

   // register reset values
   localparam logic [14:0] TENSION_RESET = 15'd2048;
   localparam logic [4:0]  SEG_POINTS_RESET = 5'd10;

   // register indexes on the configuration port
   localparam logic REG_TENSION = 1'b0;
   localparam logic REG_SEG_POINTS = 1'b1;

   // control of the shared multiply-add unit
   typedef struct packed {
      logic mul_en;
      logic scale;
   } mac_ctl_type;

   // quotient and remainder of 2^16 / d
   typedef struct packed {
      logic [15:0] quot;
      logic [4:0]  rem;
   } ustep_type;

   // step of u = floor(k * 2^16 / d) from one k to the next, for d = 2..22
   function automatic ustep_type ustep(input logic [4:0] d);
      ustep_type s;
      case (d)
         5'd2: s = '{quot: 16'd32768, rem: 5'd0};
         5'd3: s = '{quot: 16'd21845, rem: 5'd1};
         5'd4: s = '{quot: 16'd16384, rem: 5'd0};
         5'd5: s = '{quot: 16'd13107, rem: 5'd1};
         5'd6: s = '{quot: 16'd10922, rem: 5'd4};
         5'd7: s = '{quot: 16'd9362, rem: 5'd2};
         5'd8: s = '{quot: 16'd8192, rem: 5'd0};
         5'd9: s = '{quot: 16'd7281, rem: 5'd7};
         5'd10: s = '{quot: 16'd6553, rem: 5'd6};
         5'd11: s = '{quot: 16'd5957, rem: 5'd9};
         5'd12: s = '{quot: 16'd5461, rem: 5'd4};
         5'd13: s = '{quot: 16'd5041, rem: 5'd3};
         5'd14: s = '{quot: 16'd4681, rem: 5'd2};
         5'd15: s = '{quot: 16'd4369, rem: 5'd1};
         5'd16: s = '{quot: 16'd4096, rem: 5'd0};
         5'd17: s = '{quot: 16'd3855, rem: 5'd1};
         5'd18: s = '{quot: 16'd3640, rem: 5'd16};
         5'd19: s = '{quot: 16'd3449, rem: 5'd5};
         5'd20: s = '{quot: 16'd3276, rem: 5'd16};
         5'd21: s = '{quot: 16'd3120, rem: 5'd16};
         5'd22: s = '{quot: 16'd2978, rem: 5'd20};
         default: s = '{quot: 16'd0, rem: 5'd0};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cspi_req_if.sv
// control point channel: valid/ready handshake with the point payload
`default_nettype none

interface cspi_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          curve_end;

   modport source (output valid, point_x, point_y, curve_end, input ready);
   modport sink (input valid, point_x, point_y, curve_end, output ready);
endinterface

`default_nettype wire

>>> rtl/cspi_rsp_if.sv
// interpolated point channel: valid/ready handshake with the result payload
`default_nettype none

interface cspi_rsp_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic                          run_last;

   modport source (output valid, out_x, out_y, run_last, input ready);
   modport sink (input valid, out_x, out_y, run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/cspi_csr.sv
// register block on the apb-style port: tension and points per segment
`default_nettype none

module cspi_csr
   import cspi_pkg::*;
#(
   parameter int MAX_SEGMENT_POINTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready,
   output      logic [14:0] tension,
   output      logic [4:0]  seg_points
);

   logic [14:0] tension_ff, tension_in;
   logic [4:0]  seg_points_ff, seg_points_in;
   logic        wr_en;
   logic [14:0] wr_tension;
   logic [4:0]  wr_points;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   assign wr_tension = pwdata[14:0];
   assign wr_points = pwdata[4:0];

   // zero writes are dropped, points per segment clamps at the maximum
   always_comb begin
      tension_in = tension_ff;
      seg_points_in = seg_points_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_TENSION: begin
               if (wr_tension != '0) tension_in = wr_tension;
            end
            REG_SEG_POINTS: begin
               if (wr_points != '0) begin
                  seg_points_in = (wr_points > 5'(MAX_SEGMENT_POINTS)) ?
                                  5'(MAX_SEGMENT_POINTS) : wr_points;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= TENSION_RESET;
         seg_points_ff <= SEG_POINTS_RESET;
      end else begin
         tension_ff <= tension_in;
         seg_points_ff <= seg_points_in;
      end
   end

   // read back
   always_comb begin
      case (paddr[2])
         REG_SEG_POINTS: prdata = {27'd0, seg_points_ff};
         default: prdata = {17'd0, tension_ff};
      endcase
   end

   assign tension = tension_ff;
   assign seg_points = seg_points_ff;

endmodule

`default_nettype wire

>>> rtl/cspi_mac.sv
// shared multiply-add unit: registered product, then optional u scaling and add
`default_nettype none

module cspi_mac
   import cspi_pkg::*;
#(
   parameter int ACC_W = 36
) (
   input  wire logic                    clock,
   input  wire mac_ctl_type             ctl,
   input  wire logic signed [ACC_W-1:0] op_a,
   input  wire logic signed [OPB_W-1:0] op_b,
   input  wire logic signed [ACC_W-1:0] addend,
   output      logic signed [ACC_W-1:0] result
);

   localparam int PROD_W = ACC_W + OPB_W;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] prod_scaled;

   // product register
   always_comb begin
      prod_in = prod_ff;
      if (ctl.mul_en) prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // floor(product / 2^16) for horner steps, plain product for coefficients
   assign prod_scaled = ctl.scale ? (prod_ff >>> U_BITS) : prod_ff;
   assign result = ACC_W'(prod_scaled) + addend;

endmodule

`default_nettype wire

>>> rtl/cardinal_spline_interpolator_unit.sv
// Cardinal spline interpolator: control points in, interpolated points out.
// An item that opens no segment fills the window. Each segment first forms its
// coefficients, then per point does 3 horner steps on x and y, each a multiply
// and an add on the one shared multiplier, then an output step held until the
// output register is free. The point channel is ready only while no segment is
// in work. Synchronous active-high reset clears curve state and the CSRs.
`default_nettype none

module cardinal_spline_interpolator_unit
   import cspi_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int MAX_SEGMENT_POINTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   cspi_req_if.sink         req_chan,
   cspi_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int CW = COORD_WIDTH;
   localparam int ACC_W = COORD_WIDTH + 20;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMUL = 3'd1;
   localparam logic [2:0] ST_CADD = 3'd2;
   localparam logic [2:0] ST_EMUL = 3'd3;
   localparam logic [2:0] ST_EADD = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   localparam logic [1:0] SEG_HEAD = 2'd0;
   localparam logic [1:0] SEG_NORM = 2'd1;
   localparam logic [1:0] SEG_TAIL = 2'd2;

   localparam logic [2:0] SEEN_EMIT = 3'd4;

   localparam logic signed [ACC_W-1:0] COORD_MAX =
      (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) <<< T_FRAC) - ACC_W'(1);

   // truncate the Q.12 value toward zero and saturate to the coordinate range
   function automatic logic signed [CW-1:0] to_coord(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-1:0] q;
      biased = v + (v[ACC_W-1] ? TRUNC_BIAS : '0);
      q = biased >>> T_FRAC;
      if (q > COORD_MAX) q = COORD_MAX;
      if (q < COORD_MIN) q = COORD_MIN;
      return q[CW-1:0];
   endfunction

   logic [14:0] tension;
   logic [4:0]  seg_points;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          seen_ff, seen_in;
   logic signed [CW-1:0] win_x_ff [3], win_x_in [3];
   logic signed [CW-1:0] win_y_ff [3], win_y_in [3];
   logic signed [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic                last_ff, last_in;
   logic [1:0]          seg_ff, seg_in;
   logic                sel_ff, sel_in;
   logic [1:0]          step_ff, step_in;
   logic [4:0]          k_ff, k_in;
   logic [15:0]         u_ff, u_in;
   logic [4:0]          urem_ff, urem_in;
   logic signed [ACC_W-1:0] c0_ff [2], c0_in [2];
   logic signed [ACC_W-1:0] c1_ff [2], c1_in [2];
   logic signed [ACC_W-1:0] c2_ff [2], c2_in [2];
   logic signed [ACC_W-1:0] c3_ff [2], c3_in [2];
   logic signed [ACC_W-1:0] acc_ff [2], acc_in [2];
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                rsp_last_ff, rsp_last_in;

   logic signed [CW-1:0] w0, w1, w2, wp;
   logic signed [CW-1:0] pa, pb, pc, pd;
   logic signed [ACC_W-1:0] sa, sb, sc, sd;
   logic signed [ACC_W-1:0] e_da, e_bc, e_mix, e_ca, c1_fix, c3_val;
   logic signed [OPB_W-1:0] t_op, two_minus_t, u_op;
   mac_ctl_type             mac_ctl;
   logic signed [ACC_W-1:0] mac_a, mac_add, mac_res;
   logic signed [OPB_W-1:0] mac_b;
   logic [4:0]  d_val;
   ustep_type   ust;
   logic [5:0]  rem_sum;
   logic        rem_wrap;
   logic        seg_done, item_done, out_free;

   cspi_csr #(
      .MAX_SEGMENT_POINTS(MAX_SEGMENT_POINTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .tension   (tension),
      .seg_points(seg_points)
   );

   cspi_mac #(
      .ACC_W(ACC_W)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .addend(mac_add),
      .result(mac_res)
   );

   // window of the coordinate in work
   always_comb begin
      w0 = sel_ff ? win_y_ff[0] : win_x_ff[0];
      w1 = sel_ff ? win_y_ff[1] : win_x_ff[1];
      w2 = sel_ff ? win_y_ff[2] : win_x_ff[2];
      wp = sel_ff ? py_ff : px_ff;
   end

   // four points of the segment, ends duplicated for head and tail
   always_comb begin
      case (seg_ff)
         SEG_HEAD: begin pa = w0; pb = w0; pc = w1; pd = w2; end
         SEG_TAIL: begin pa = w1; pb = w2; pc = wp; pd = wp; end
         default:  begin pa = w0; pb = w1; pc = w2; pd = wp; end
      endcase
   end

   // coefficient terms: c0 = t(d-a) + (2-t)(b-c), c1 = t(2a+b-2c-d) - 3(b-c),
   // c2 = t(c-a), c3 = b, all at scale 2^12
   always_comb begin
      sa = ACC_W'(pa);
      sb = ACC_W'(pb);
      sc = ACC_W'(pc);
      sd = ACC_W'(pd);
      e_da = sd - sa;
      e_bc = sb - sc;
      e_mix = (sa <<< 1) + sb - (sc <<< 1) - sd;
      e_ca = sc - sa;
      c1_fix = -((e_bc <<< (T_FRAC + 1)) + (e_bc <<< T_FRAC));
      c3_val = sb <<< T_FRAC;
   end

   assign t_op = OPB_W'({2'b00, tension});
   assign two_minus_t = TWO_Q12 - t_op;
   assign u_op = OPB_W'({1'b0, u_ff});

   // operand selection for the shared unit
   always_comb begin
      mac_ctl.mul_en = (state_ff == ST_CMUL) || (state_ff == ST_EMUL);
      mac_ctl.scale = (state_ff == ST_EADD);
      mac_a = acc_ff[sel_ff];
      mac_b = u_op;
      mac_add = '0;
      if (state_ff == ST_CMUL) begin
         case (step_ff)
            2'd0: begin mac_a = e_da; mac_b = t_op; end
            2'd1: begin mac_a = e_bc; mac_b = two_minus_t; end
            2'd2: begin mac_a = e_mix; mac_b = t_op; end
            default: begin mac_a = e_ca; mac_b = t_op; end
         endcase
      end
      if (state_ff == ST_CADD) begin
         case (step_ff)
            2'd1: mac_add = c0_ff[sel_ff];
            2'd2: mac_add = c1_fix;
            default: mac_add = '0;
         endcase
      end else if (state_ff == ST_EADD) begin
         case (step_ff)
            2'd0: mac_add = c1_ff[sel_ff];
            2'd1: mac_add = c2_ff[sel_ff];
            default: mac_add = c3_ff[sel_ff];
         endcase
      end
   end

   // u advances by 2^16/(G+1) per point, carrying the remainder
   always_comb begin
      d_val = 5'(seg_points + 5'd1);
      ust = ustep(d_val);
      rem_sum = {1'b0, urem_ff} + {1'b0, ust.rem};
      rem_wrap = (rem_sum >= {1'b0, d_val});
   end

   assign seg_done = (k_ff == 5'(seg_points - 5'd1));
   assign item_done = (seg_ff == SEG_TAIL) || ((seg_ff == SEG_NORM) && !last_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      seen_in = seen_ff;
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      px_in = px_ff;
      py_in = py_ff;
      last_in = last_ff;
      seg_in = seg_ff;
      sel_in = sel_ff;
      step_in = step_ff;
      k_in = k_ff;
      u_in = u_ff;
      urem_in = urem_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      c3_in = c3_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               px_in = req_chan.point_x;
               py_in = req_chan.point_y;
               last_in = req_chan.curve_end;
               if (seen_ff < 3'd3) begin
                  // still filling the window
                  win_x_in[seen_ff[1:0]] = req_chan.point_x;
                  win_y_in[seen_ff[1:0]] = req_chan.point_y;
                  seen_in = req_chan.curve_end ? 3'd0 : 3'(seen_ff + 3'd1);
               end else begin
                  seg_in = (seen_ff == 3'd3) ? SEG_HEAD : SEG_NORM;
                  sel_in = 1'b0;
                  step_in = 2'd0;
                  state_in = ST_CMUL;
               end
            end
         end
         ST_CMUL: state_in = ST_CADD;
         ST_CADD: begin
            case (step_ff)
               2'd0: c0_in[sel_ff] = mac_res;
               2'd1: c0_in[sel_ff] = mac_res;
               2'd2: c1_in[sel_ff] = mac_res;
               default: begin
                  c2_in[sel_ff] = mac_res;
                  c3_in[sel_ff] = c3_val;
               end
            endcase
            if (step_ff != 2'd3) begin
               step_in = 2'(step_ff + 2'd1);
               state_in = ST_CMUL;
            end else if (!sel_ff) begin
               sel_in = 1'b1;
               step_in = 2'd0;
               state_in = ST_CMUL;
            end else begin
               // coefficients ready, first point at u = 0
               sel_in = 1'b0;
               step_in = 2'd0;
               k_in = '0;
               u_in = '0;
               urem_in = '0;
               acc_in[0] = c0_ff[0];
               acc_in[1] = c0_ff[1];
               state_in = ST_EMUL;
            end
         end
         ST_EMUL: state_in = ST_EADD;
         ST_EADD: begin
            acc_in[sel_ff] = mac_res;
            if (step_ff != 2'd2) begin
               step_in = 2'(step_ff + 2'd1);
               state_in = ST_EMUL;
            end else if (!sel_ff) begin
               sel_in = 1'b1;
               step_in = 2'd0;
               state_in = ST_EMUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = to_coord(acc_ff[0]);
               rsp_y_in = to_coord(acc_ff[1]);
               rsp_last_in = seg_done && item_done;
               sel_in = 1'b0;
               step_in = 2'd0;
               if (!seg_done) begin
                  // next point of this segment
                  k_in = 5'(k_ff + 5'd1);
                  u_in = 16'(u_ff + ust.quot + {15'd0, rem_wrap});
                  urem_in = rem_wrap ? 5'(rem_sum - {1'b0, d_val}) : rem_sum[4:0];
                  acc_in[0] = c0_ff[0];
                  acc_in[1] = c0_ff[1];
                  state_in = ST_EMUL;
               end else if (seg_ff == SEG_HEAD) begin
                  seg_in = SEG_NORM;
                  state_in = ST_CMUL;
               end else if ((seg_ff == SEG_NORM) && last_ff) begin
                  seg_in = SEG_TAIL;
                  state_in = ST_CMUL;
               end else begin
                  // item finished: slide the window
                  win_x_in[0] = win_x_ff[1];
                  win_x_in[1] = win_x_ff[2];
                  win_x_in[2] = px_ff;
                  win_y_in[0] = win_y_ff[1];
                  win_y_in[1] = win_y_ff[2];
                  win_y_in[2] = py_ff;
                  seen_in = last_ff ? 3'd0 : SEEN_EMIT;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         win_x_ff <= win_x_in;
         win_y_ff <= win_y_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      last_ff <= last_in;
      seg_ff <= seg_in;
      sel_ff <= sel_in;
      step_ff <= step_in;
      k_ff <= k_in;
      u_ff <= u_in;
      urem_ff <= urem_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      c3_ff <= c3_in;
      acc_ff <= acc_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   // channel ports
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_x = rsp_x_ff;
   assign rsp_chan.out_y = rsp_y_ff;
   assign rsp_chan.run_last = rsp_last_ff;

endmodule

`default_nettype wire
